// ===== rtl/cng_pkg.sv =====
// Shared constants, coefficient tables and stage payload types for the coloured noise core.
`timescale 1ns / 1ps
`default_nettype none

package cng_pkg;

  localparam int SampleW = 16;               // Q1.(SampleW-1) audio samples
  localparam int StateW  = 32;               // Q8.24 filter state
  localparam int FracW   = 24;               // fractional bits of states and coefficients
  localparam int CoefW   = FracW + 1;        // signed coefficient width
  localparam int NumPole = 6;

  localparam int TdataW  = ((SampleW + 7) / 8) * 8;
  localparam int WideW   = FracW + 1;        // sample widened to Q1.24
  localparam int InShift = WideW - SampleW;
  localparam int GainPW  = CoefW + WideW;    // coefficient times widened sample
  localparam int AccW    = CoefW + StateW + 1;
  localparam int RndW    = AccW - FracW;
  localparam int SumW    = StateW + 3;       // eight pink terms

  localparam logic signed [CoefW-1:0] PoleCoef [NumPole] = '{
    25'sd16758090, 25'sd16665144, 25'sd16257122,
    25'sd14537458, 25'sd9227469,  -25'sd12777528
  };
  localparam logic signed [CoefW-1:0] GainCoef [NumPole] = '{
    25'sd931436,  25'sd1259565, 25'sd2581208,
    25'sd5209084, 25'sd8941454, -25'sd283501
  };
  localparam logic signed [CoefW-1:0] KDirect    = 25'sd8995943;
  localparam logic signed [CoefW-1:0] KDelay     = 25'sd1944916;
  localparam logic signed [CoefW-1:0] KPinkScale = 25'sd1845494;
  localparam logic signed [CoefW-1:0] KBrownIn   = 25'sd335544;
  localparam logic signed [CoefW-1:0] KBrownDiv  = 25'sd16448251;

  typedef enum logic [1:0] {
    ColWhite = 2'd0,
    ColPink  = 2'd1,
    ColBrown = 2'd2
  } color_e;

  // products that depend on the sample only
  typedef struct packed {
    color_e                             color;
    logic signed [SampleW-1:0]          w;
    logic        [NumPole-1:0][GainPW-1:0] gain;
    logic signed [StateW-1:0]           direct;
    logic signed [StateW-1:0]           delay;
    logic signed [StateW-1:0]           brown_in;
  } pre_t;

  // filter bank view for the output stages; pink[NumPole] is the delayed term
  typedef struct packed {
    color_e                             color;
    logic signed [SampleW-1:0]          w;
    logic        [NumPole:0][StateW-1:0] pink;
    logic signed [StateW-1:0]           direct;
    logic signed [StateW-1:0]           level;
  } filt_t;

  typedef struct packed {
    logic sum_load;
    logic out_load;
  } out_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cng_pre.sv =====
// Sample-only products: pole gains, direct and delayed pink terms, integrator input.
`timescale 1ns / 1ps
`default_nettype none

module cng_pre (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  cng_pkg::color_e                   color_i,
  input  logic signed [cng_pkg::SampleW-1:0] w_i,
  output cng_pkg::pre_t                     pre_o
);
  import cng_pkg::*;

  localparam logic [GainPW-1:0] GainHalf =
    {{(GainPW - FracW){1'b0}}, 1'b1, {(FracW - 1){1'b0}}};

  function automatic logic signed [StateW-1:0] rnd_gain(input logic signed [GainPW-1:0] p);
    logic signed [GainPW-1:0] t;
    t = p + $signed(GainHalf);
    return StateW'($signed(t[GainPW-1:FracW]));
  endfunction

  logic signed [WideW-1:0]  w24;
  logic signed [GainPW-1:0] gprod [NumPole];
  logic signed [GainPW-1:0] dprod, lprod, bprod;
  pre_t                     pre_d, pre_q;

  assign w24 = {w_i, {InShift{1'b0}}};

  always_comb begin
    for (int k = 0; k < NumPole; k++) begin
      gprod[k] = GainPW'(GainCoef[k]) * GainPW'(w24);
    end
    dprod = GainPW'(KDirect) * GainPW'(w24);
    lprod = GainPW'(KDelay) * GainPW'(w24);
    bprod = GainPW'(KBrownIn) * GainPW'(w24);

    pre_d.color = color_i;
    pre_d.w     = w_i;
    for (int k = 0; k < NumPole; k++) begin
      pre_d.gain[k] = gprod[k];
    end
    pre_d.direct   = rnd_gain(dprod);
    // small enough that it never reaches the state limits
    pre_d.delay    = rnd_gain(lprod);
    pre_d.brown_in = rnd_gain(bprod);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pre_q <= pre_d;
    end
  end

  assign pre_o = pre_q;

endmodule

`default_nettype wire

// ===== rtl/cng_filt.sv =====
// Pink filter bank and brown integrator state, one update per sample.
`timescale 1ns / 1ps
`default_nettype none

module cng_filt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  cng_pkg::pre_t  pre_i,
  output cng_pkg::filt_t filt_o
);
  import cng_pkg::*;

  localparam logic [AccW-1:0] AccHalf =
    {{(AccW - FracW){1'b0}}, 1'b1, {(FracW - 1){1'b0}}};
  localparam logic signed [RndW-1:0] StMax =
    $signed({{(RndW - StateW + 1){1'b0}}, {(StateW - 1){1'b1}}});
  localparam logic signed [RndW-1:0] StMin =
    $signed({{(RndW - StateW + 1){1'b1}}, {(StateW - 1){1'b0}}});

  function automatic logic signed [RndW-1:0] round_acc(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    t = v + $signed(AccHalf);
    return $signed(t[AccW-1:FracW]);
  endfunction

  function automatic logic signed [StateW-1:0] sat_state(input logic signed [RndW-1:0] v);
    logic signed [StateW-1:0] r;
    if (v > StMax) begin
      r = StMax[StateW-1:0];
    end else if (v < StMin) begin
      r = StMin[StateW-1:0];
    end else begin
      r = v[StateW-1:0];
    end
    return r;
  endfunction

  logic signed [StateW-1:0]  state_q [NumPole+1];
  logic signed [StateW-1:0]  pole_d  [NumPole];
  logic signed [AccW-1:0]    pole_acc [NumPole];
  logic signed [StateW-1:0]  level_q, level_d;
  logic signed [StateW:0]    brown_sum;
  logic signed [AccW-1:0]    brown_prod;
  logic signed [StateW-1:0]  old_q, direct_q;
  logic signed [SampleW-1:0] w_q;
  color_e                    color_q;

  always_comb begin
    for (int k = 0; k < NumPole; k++) begin
      pole_acc[k] = AccW'(PoleCoef[k]) * AccW'(state_q[k]) + AccW'($signed(pre_i.gain[k]));
      pole_d[k]   = sat_state(round_acc(pole_acc[k]));
    end
    brown_sum  = (StateW + 1)'(level_q) + (StateW + 1)'($signed(pre_i.brown_in));
    brown_prod = AccW'(brown_sum) * AccW'(KBrownDiv);
    level_d    = sat_state(round_acc(brown_prod));
  end

  // only the selected colour advances its own state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NumPole; k++) begin
        state_q[k] <= '0;
      end
      level_q <= '0;
    end else if (load_i) begin
      if (pre_i.color == ColPink) begin
        for (int k = 0; k < NumPole; k++) begin
          state_q[k] <= pole_d[k];
        end
        state_q[NumPole] <= pre_i.delay;
      end else if (pre_i.color == ColBrown) begin
        level_q <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      color_q  <= pre_i.color;
      w_q      <= pre_i.w;
      direct_q <= pre_i.direct;
      if (pre_i.color == ColPink) begin
        old_q <= state_q[NumPole];
      end
    end
  end

  always_comb begin
    filt_o.color  = color_q;
    filt_o.w      = w_q;
    for (int k = 0; k < NumPole; k++) begin
      filt_o.pink[k] = state_q[k];
    end
    filt_o.pink[NumPole] = old_q;
    filt_o.direct = direct_q;
    filt_o.level  = level_q;
  end

endmodule

`default_nettype wire

// ===== rtl/cng_out.sv =====
// Output side: pink sum, scaling, rounding and saturation to the sample range.
`timescale 1ns / 1ps
`default_nettype none

module cng_out (
  input  logic                               clk_i,
  input  cng_pkg::out_ctrl_t                 ctrl_i,
  input  cng_pkg::filt_t                     filt_i,
  output logic signed [cng_pkg::SampleW-1:0] noise_o
);
  import cng_pkg::*;

  localparam int BrSh   = 27 - SampleW;          // x3.5 and the halving
  localparam int PinkSh = 26 - SampleW;
  localparam int B7W    = StateW + 3;
  localparam int BaseW  = B7W - BrSh;
  localparam int ProdW  = SumW + CoefW;
  localparam int Y1W    = ProdW - FracW;
  localparam int YW     = Y1W - PinkSh;

  localparam logic [B7W-1:0]   BrHalf   = B7W'(1) << (BrSh - 1);
  localparam logic [ProdW-1:0] ProdHalf = ProdW'(1) << (FracW - 1);
  localparam logic [Y1W-1:0]   Y1Half   = Y1W'(1) << (PinkSh - 1);
  localparam logic signed [YW-1:0] SMax =
    $signed({{(YW - SampleW + 1){1'b0}}, {(SampleW - 1){1'b1}}});
  localparam logic signed [YW-1:0] SMin =
    $signed({{(YW - SampleW + 1){1'b1}}, {(SampleW - 1){1'b0}}});

  // sum stage
  logic signed [SumW-1:0]    sum_d, sum_q;
  logic signed [SampleW:0]   white_r;
  logic signed [SampleW-1:0] white_y;
  logic signed [B7W-1:0]     b7, b7_r;
  logic signed [BaseW-1:0]   base_d, base_q;
  color_e                    color_q;

  always_comb begin
    sum_d = SumW'($signed(filt_i.direct));
    for (int k = 0; k <= NumPole; k++) begin
      sum_d = sum_d + SumW'($signed(filt_i.pink[k]));
    end
    white_r = {filt_i.w[SampleW-1], filt_i.w} + (SampleW + 1)'(1);
    white_y = $signed(white_r[SampleW:1]);
    b7      = B7W'($signed(filt_i.level)) * B7W'(4'sd7);
    b7_r    = b7 + $signed(BrHalf);
    if (filt_i.color == ColWhite) begin
      base_d = BaseW'(white_y);
    end else begin
      base_d = $signed(b7_r[B7W-1:BrSh]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_load) begin
      sum_q   <= sum_d;
      base_q  <= base_d;
      color_q <= filt_i.color;
    end
  end

  // scale stage
  logic signed [ProdW-1:0]   prod, prod_r;
  logic signed [Y1W-1:0]     y1, y1_r;
  logic signed [YW-1:0]      y_sel;
  logic signed [SampleW-1:0] noise_d, noise_q;

  always_comb begin
    prod   = ProdW'(sum_q) * ProdW'(KPinkScale);
    prod_r = prod + $signed(ProdHalf);
    y1     = $signed(prod_r[ProdW-1:FracW]);
    y1_r   = y1 + $signed(Y1Half);
    if (color_q == ColPink) begin
      y_sel = $signed(y1_r[Y1W-1:PinkSh]);
    end else begin
      y_sel = YW'(base_q);
    end
    if (y_sel > SMax) begin
      noise_d = SMax[SampleW-1:0];
    end else if (y_sel < SMin) begin
      noise_d = SMin[SampleW-1:0];
    end else begin
      noise_d = y_sel[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      noise_q <= noise_d;
    end
  end

  assign noise_o = noise_q;

endmodule

`default_nettype wire

// ===== rtl/colored_noise_generator_core.sv =====
// Coloured noise core: one white sample in, one white, pink or brown sample out.
// Five register stages (input, pre, filter, sum, output) carry each request in order to m_axis.
// Throughput is one sample per cycle while m_axis_tready is high, set by the filter-state
// update stage, where each pole and the integrator do one state multiply per cycle; stages close up bubbles.
// Reset clears filter states, integrator level, all stage valids and selects white;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module colored_noise_generator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cng_pkg::TdataW-1:0]  s_axis_tdata,   // [15:0] white_sample
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cng_pkg::TdataW-1:0]  m_axis_tdata,   // [15:0] noise_sample
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_data_i      // noise_color
);
  import cng_pkg::*;

  color_e cfg_color_q;

  assign cfg_ready_o = 1'b1;

  // unused code three behaves as brown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_color_q <= ColWhite;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_data_i)
        ColWhite: cfg_color_q <= ColWhite;
        ColPink:  cfg_color_q <= ColPink;
        default:  cfg_color_q <= ColBrown;
      endcase
    end
  end

  // stage handshake
  logic in_vld_q, pre_vld_q, filt_vld_q, sum_vld_q, out_vld_q;
  logic in_rdy, pre_rdy, filt_rdy, sum_rdy, out_rdy;
  logic in_load, pre_load, filt_load;

  assign out_rdy  = !out_vld_q  || m_axis_tready;
  assign sum_rdy  = !sum_vld_q  || out_rdy;
  assign filt_rdy = !filt_vld_q || sum_rdy;
  assign pre_rdy  = !pre_vld_q  || filt_rdy;
  assign in_rdy   = !in_vld_q   || pre_rdy;

  assign in_load   = in_rdy && s_axis_tvalid;
  assign pre_load  = pre_rdy && in_vld_q;
  assign filt_load = filt_rdy && pre_vld_q;

  out_ctrl_t out_ctrl;
  assign out_ctrl.sum_load = sum_rdy && filt_vld_q;
  assign out_ctrl.out_load = out_rdy && sum_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      pre_vld_q  <= 1'b0;
      filt_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_rdy)   in_vld_q   <= s_axis_tvalid;
      if (pre_rdy)  pre_vld_q  <= in_vld_q;
      if (filt_rdy) filt_vld_q <= pre_vld_q;
      if (sum_rdy)  sum_vld_q  <= filt_vld_q;
      if (out_rdy)  out_vld_q  <= sum_vld_q;
    end
  end

  // input register
  logic signed [SampleW-1:0] in_w_q;
  color_e                    in_color_q;

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_w_q     <= $signed(s_axis_tdata[SampleW-1:0]);
      in_color_q <= cfg_color_q;
    end
  end

  pre_t                      pre;
  filt_t                     filt;
  logic signed [SampleW-1:0] noise;

  cng_pre u_pre (
    .clk_i   (clk_i),
    .load_i  (pre_load),
    .color_i (in_color_q),
    .w_i     (in_w_q),
    .pre_o   (pre)
  );

  cng_filt u_filt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (filt_load),
    .pre_i  (pre),
    .filt_o (filt)
  );

  cng_out u_out (
    .clk_i   (clk_i),
    .ctrl_i  (out_ctrl),
    .filt_i  (filt),
    .noise_o (noise)
  );

  assign s_axis_tready = in_rdy;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TdataW'($unsigned(noise));

  // input only blocks when every stage holds a request
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && pre_vld_q && filt_vld_q && sum_vld_q && out_vld_q))
    else $error("input blocked with a free stage");

  a_out_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(sum_vld_q))
    else $error("result appeared without a request in the sum stage");

  a_filt_handed_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(filt_vld_q) |-> $past(sum_rdy))
    else $error("filter stage request dropped while sum stage was full");

endmodule

`default_nettype wire
